// ===== rtl/source_text_tokenizer_macros.svh =====
// Assertion macros used by the tokenizer top level.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Checks that an implication holds on every clock edge outside reset.
`define STT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
package stt_pkg;

  localparam int unsigned PosW = 24;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } stt_in_t;

  typedef struct packed {
    logic [5:0]      token_kind;
    logic [PosW-1:0] token_offset;
    logic [PosW-1:0] token_length;
    logic [PosW-1:0] token_line;
    logic [PosW-1:0] token_column;
    logic            last_of_run;
  } stt_out_t;

  localparam logic [5:0] KIND_END    = 6'd0;
  localparam logic [5:0] KIND_IDENT  = 6'd1;
  localparam logic [5:0] KIND_INT    = 6'd2;
  localparam logic [5:0] KIND_FLOAT  = 6'd3;
  localparam logic [5:0] KIND_STRING = 6'd4;
  localparam logic [5:0] KIND_CHAR   = 6'd5;

  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  // Token record produced by the scanner before the output queue.
  typedef struct packed {
    logic [5:0] kind;
    logic       use_start;   // position from the saved start, else current
    logic [1:0] len_sel;     // 0: measured, 1: one, 2: two, 3: zero
    logic       adv_len;     // measured length includes the byte taken now
    logic       last;
  } stt_tok_ctl_t;

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic wants_pair(input logic [7:0] b);
    return b == 8'h3A || b == 8'h2B || b == 8'h2D || b == 8'h2A || b == 8'h2F ||
           b == 8'h3D || b == 8'h21 || b == 8'h3C || b == 8'h3E || b == 8'h26 ||
           b == 8'h7C;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    k = KIND_END;
    unique case (b)
      8'h28: k = 6'd6;   8'h29: k = 6'd7;   8'h5B: k = 6'd8;
      8'h5D: k = 6'd9;   8'h7B: k = 6'd10;  8'h7D: k = 6'd11;
      8'h3B: k = 6'd12;  8'h2C: k = 6'd13;  8'h3A: k = 6'd14;
      8'h2E: k = 6'd16;  8'h23: k = 6'd19;  8'h40: k = 6'd20;
      8'h24: k = 6'd21;  8'h2B: k = 6'd22;  8'h2D: k = 6'd23;
      8'h2A: k = 6'd24;  8'h2F: k = 6'd25;  8'h25: k = 6'd26;
      8'h3C: k = 6'd29;  8'h3E: k = 6'd30;  8'h26: k = 6'd35;
      8'h7C: k = 6'd36;  8'h5E: k = 6'd37;  8'h7E: k = 6'd38;
      8'h21: k = 6'd39;  8'h3D: k = 6'd40;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = KIND_END;
    if (a == 8'h3A && b == 8'h3A) k = 6'd15;
    else if (a == 8'h2B && b == 8'h2B) k = 6'd45;
    else if (a == 8'h2B && b == 8'h3D) k = 6'd41;
    else if (a == 8'h2D && b == 8'h3E) k = 6'd17;
    else if (a == 8'h2D && b == 8'h2D) k = 6'd46;
    else if (a == 8'h2D && b == 8'h3D) k = 6'd42;
    else if (a == 8'h2A && b == 8'h3D) k = 6'd43;
    else if (a == 8'h2F && b == 8'h3D) k = 6'd44;
    else if (a == 8'h3D && b == 8'h3D) k = 6'd27;
    else if (a == 8'h3D && b == 8'h3E) k = 6'd18;
    else if (a == 8'h21 && b == 8'h3D) k = 6'd28;
    else if (a == 8'h3C && b == 8'h3D) k = 6'd31;
    else if (a == 8'h3E && b == 8'h3D) k = 6'd32;
    else if (a == 8'h26 && b == 8'h26) k = 6'd33;
    else if (a == 8'h7C && b == 8'h7C) k = 6'd34;
    return k;
  endfunction

endpackage

// ===== rtl/stt_scan.sv =====
// Front part: scanner state machine and position counters. Each accepted
// byte produces up to two token records in the same cycle.
module stt_scan #(
  parameter int unsigned PW = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  stt_pkg::stt_in_t    in_item,
  output logic [1:0]          tok_count,
  output stt_pkg::stt_tok_ctl_t tok0,
  output stt_pkg::stt_tok_ctl_t tok1,
  output logic [PW-1:0]       start_offset,
  output logic [PW-1:0]       start_line,
  output logic [PW-1:0]       start_column,
  output logic [PW-1:0]       position,
  output logic [PW-1:0]       current_line,
  output logic [PW-1:0]       current_column
);
  import stt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_IDENT, S_NUM, S_STR, S_STR_ESC, S_CHR_OPEN, S_CHR_ESC, S_CHR_BODY,
    S_PUNCT, S_LINE, S_BLOCK, S_BLOCK_STAR
  } mode_t;

  localparam logic [PW-1:0] PosMax = {PW{1'b1}};
  localparam logic [PW-1:0] One = {{(PW-1){1'b0}}, 1'b1};

  mode_t      mode, mode_next;
  logic [7:0] pending_byte, pending_next;
  logic       saw_dot, saw_dot_next;
  logic       adv, capture, eoi;
  logic [7:0] b;
  logic       n0, n1;
  stt_tok_ctl_t t0, t1;
  logic       beg;

  assign b   = in_item.char_byte;
  assign eoi = in_item.end_of_input;

  always_comb begin
    mode_next    = mode;
    pending_next = pending_byte;
    saw_dot_next = saw_dot;
    adv          = 1'b0;
    capture      = 1'b0;
    beg          = 1'b0;
    n0           = 1'b0;
    n1           = 1'b0;
    t0           = '{kind: KIND_END, use_start: 1'b1, len_sel: 2'd0, adv_len: 1'b0,
                     last: 1'b0};
    t1           = t0;
    if (eoi) begin
      // Flush any pending token, then the end token at the current position.
      unique case (mode)
        S_IDENT: begin n0 = 1'b1; t0.kind = KIND_IDENT; end
        S_NUM: begin n0 = 1'b1; t0.kind = saw_dot ? KIND_FLOAT : KIND_INT; end
        S_STR, S_STR_ESC: begin n0 = 1'b1; t0.kind = KIND_STRING; end
        S_CHR_OPEN, S_CHR_ESC, S_CHR_BODY: begin n0 = 1'b1; t0.kind = KIND_CHAR; end
        S_PUNCT: begin
          n0 = 1'b1; t0.kind = single_kind(pending_byte); t0.len_sel = 2'd1;
        end
        default: n0 = 1'b0;
      endcase
      n1 = 1'b1;
      t1 = '{kind: KIND_END, use_start: 1'b0, len_sel: 2'd3, adv_len: 1'b0, last: 1'b1};
    end else begin
      unique case (mode)
        S_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == CH_UNDER) adv = 1'b1;
          else begin n0 = 1'b1; t0.kind = KIND_IDENT; beg = 1'b1; end
        end
        S_NUM: begin
          if (is_digit(b) || b == CH_DOT || b == CH_UNDER) begin
            adv = 1'b1;
            if (b == CH_DOT) saw_dot_next = 1'b1;
          end else begin
            n0 = 1'b1; t0.kind = saw_dot ? KIND_FLOAT : KIND_INT; beg = 1'b1;
          end
        end
        S_STR: begin
          adv = 1'b1;
          if (b == CH_DQ) begin
            n0 = 1'b1; t0.kind = KIND_STRING; t0.adv_len = 1'b1; mode_next = S_IDLE;
          end else if (b == CH_BSL) mode_next = S_STR_ESC;
        end
        S_STR_ESC: begin adv = 1'b1; mode_next = S_STR; end
        S_CHR_OPEN: begin
          adv = 1'b1; mode_next = (b == CH_BSL) ? S_CHR_ESC : S_CHR_BODY;
        end
        S_CHR_ESC: begin adv = 1'b1; mode_next = S_CHR_BODY; end
        S_CHR_BODY: begin
          adv = 1'b1; n0 = 1'b1; t0.kind = KIND_CHAR; t0.adv_len = 1'b1;
          mode_next = S_IDLE;
        end
        S_PUNCT: begin
          if (pending_byte == CH_SLASH && b == CH_SLASH) begin
            adv = 1'b1; mode_next = S_LINE;
          end else if (pending_byte == CH_SLASH && b == CH_STAR) begin
            adv = 1'b1; mode_next = S_BLOCK;
          end else if (pair_kind(pending_byte, b) != KIND_END) begin
            adv = 1'b1; n0 = 1'b1; t0.kind = pair_kind(pending_byte, b);
            t0.len_sel = 2'd2; mode_next = S_IDLE;
          end else begin
            n0 = 1'b1; t0.kind = single_kind(pending_byte); t0.len_sel = 2'd1;
            beg = 1'b1;
          end
        end
        S_LINE: begin adv = 1'b1; if (b == CH_NL) mode_next = S_IDLE; end
        S_BLOCK: begin adv = 1'b1; if (b == CH_STAR) mode_next = S_BLOCK_STAR; end
        S_BLOCK_STAR: begin
          adv = 1'b1;
          if (b == CH_SLASH) mode_next = S_IDLE;
          else if (b != CH_STAR) mode_next = S_BLOCK;
        end
        default: beg = 1'b1;
      endcase
      if (beg) begin
        adv = 1'b1;
        mode_next = S_IDLE;
        if (!is_space(b)) begin
          capture = 1'b1;
          if (is_alpha(b) || b == CH_UNDER) mode_next = S_IDENT;
          else if (is_digit(b)) begin mode_next = S_NUM; saw_dot_next = 1'b0; end
          else if (b == CH_DQ) mode_next = S_STR;
          else if (b == CH_SQ) mode_next = S_CHR_OPEN;
          else if (wants_pair(b)) begin mode_next = S_PUNCT; pending_next = b; end
          else begin
            // A single-byte token starts at the current position.
            if (n0) begin
              n1 = 1'b1;
              t1 = '{kind: single_kind(b), use_start: 1'b0, len_sel: 2'd1,
                     adv_len: 1'b0, last: 1'b0};
            end else begin
              n0 = 1'b1;
              t0 = '{kind: single_kind(b), use_start: 1'b0, len_sel: 2'd1,
                     adv_len: 1'b0, last: 1'b0};
            end
          end
        end
      end
      if (n1) t1.last = 1'b1;
      else t0.last = 1'b1;
    end
  end

  assign tok_count = in_valid ? {1'b0, n0} + {1'b0, n1} : 2'd0;
  assign tok0 = n0 ? t0 : t1;
  assign tok1 = t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= S_IDLE; pending_byte <= '0; saw_dot <= 1'b0;
      start_offset <= '0; start_line <= One; start_column <= One;
      position <= '0; current_line <= One; current_column <= One;
    end else if (in_valid) begin
      if (eoi) begin
        mode <= S_IDLE; pending_byte <= '0; saw_dot <= 1'b0;
        start_offset <= '0; start_line <= One; start_column <= One;
        position <= '0; current_line <= One; current_column <= One;
      end else begin
        mode <= mode_next; pending_byte <= pending_next; saw_dot <= saw_dot_next;
        if (capture) begin
          start_offset <= position; start_line <= current_line;
          start_column <= current_column;
        end
        if (adv) begin
          if (position != PosMax) position <= position + One;
          if (b == CH_NL) begin
            if (current_line != PosMax) current_line <= current_line + One;
            current_column <= One;
          end else if (current_column != PosMax) current_column <= current_column + One;
        end
      end
    end
  end
endmodule

// ===== rtl/stt_queue.sv =====
// Back part: four-entry result queue with a registered head. Tokens are
// resolved to full records on the way in.
module stt_queue #(
  parameter int unsigned PW = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            tok_count,
  input  stt_pkg::stt_tok_ctl_t tok0,
  input  stt_pkg::stt_tok_ctl_t tok1,
  input  logic [PW-1:0]         start_offset,
  input  logic [PW-1:0]         start_line,
  input  logic [PW-1:0]         start_column,
  input  logic [PW-1:0]         position,
  input  logic [PW-1:0]         current_line,
  input  logic [PW-1:0]         current_column,
  input  logic                  pop,
  output logic                  empty,
  output logic                  room2,
  output stt_pkg::stt_out_t     head
);
  import stt_pkg::*;

  stt_out_t   mem [4];
  logic [1:0] rd, wr;
  logic [2:0] cnt;
  logic       do_pop;
  stt_out_t   r0, r1;

  function automatic stt_out_t build(input stt_tok_ctl_t t, input logic [PW-1:0] so,
    input logic [PW-1:0] sl, input logic [PW-1:0] sc, input logic [PW-1:0] po,
    input logic [PW-1:0] cl, input logic [PW-1:0] cc);
    stt_out_t   r;
    logic [PW-1:0] len;
    logic [PW-1:0] po_end;
    // A token closed by the byte taken now ends at the saturated next position.
    po_end = (t.adv_len && po != {PW{1'b1}}) ? po + {{(PW-1){1'b0}}, 1'b1} : po;
    unique case (t.len_sel)
      2'd0: len = po_end - so;
      2'd1: len = {{(PW-1){1'b0}}, 1'b1};
      2'd2: len = {{(PW-2){1'b0}}, 2'b10};
      default: len = '0;
    endcase
    r.token_kind   = t.kind;
    r.token_offset = PosW'(t.use_start ? so : po);
    r.token_length = PosW'(len);
    r.token_line   = PosW'(t.use_start ? sl : cl);
    r.token_column = PosW'(t.use_start ? sc : cc);
    r.last_of_run  = t.last;
    return r;
  endfunction

  assign r0 = build(tok0, start_offset, start_line, start_column, position,
                    current_line, current_column);
  assign r1 = build(tok1, start_offset, start_line, start_column, position,
                    current_line, current_column);

  assign empty  = cnt == 3'd0;
  assign do_pop = pop && !empty;
  assign room2  = cnt <= 3'd2;
  assign head   = mem[rd];

  always_ff @(posedge clk) begin
    if (tok_count != 2'd0) mem[wr] <= r0;
    if (tok_count == 2'd2) mem[wr + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0; wr <= '0; cnt <= '0;
    end else begin
      wr  <= wr + tok_count;
      if (do_pop) rd <= rd + 2'd1;
      cnt <= cnt + {1'b0, tok_count} - {2'b0, do_pop};
    end
  end
endmodule

// ===== rtl/source_text_tokenizer.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | push / full        | in_item  (stt_in_t)
// result  | out       | pop / empty        | out_item (stt_out_t)
// One byte is taken per cycle while the result queue has room for two tokens.
// Tokens are registered into the result queue as their byte is taken and reach out_item at its head.
// The four-entry result queue sets the stall point: full rises with three waiting.
// Reset (rst, synchronous) clears the scanner and empties the queue.
module source_text_tokenizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  stt_pkg::stt_in_t  in_item,
  output logic              empty,
  input  logic              pop,
  output stt_pkg::stt_out_t out_item
);
  import stt_pkg::*;
  `include "source_text_tokenizer_macros.svh"

  logic              acc, room2;
  logic [1:0]        tok_count;
  stt_tok_ctl_t      tok0, tok1;
  logic [PosW-1:0]   so, sl, sc, po, cl, cc;

  assign full = !room2;
  assign acc  = push && !full;

  stt_scan #(.PW(PosW)) u_scan (
    .clk, .rst, .in_valid(acc), .in_item, .tok_count, .tok0, .tok1,
    .start_offset(so), .start_line(sl), .start_column(sc),
    .position(po), .current_line(cl), .current_column(cc)
  );

  stt_queue #(.PW(PosW)) u_queue (
    .clk, .rst, .tok_count, .tok0, .tok1,
    .start_offset(so), .start_line(sl), .start_column(sc),
    .position(po), .current_line(cl), .current_column(cc),
    .pop, .empty, .room2, .head(out_item)
  );

  `STT_ASSERT_IMPLY(a_end_has_token, clk, rst, acc && in_item.end_of_input, tok_count != 2'd0, "end of input without token")
  `STT_ASSERT_NEXT(a_token_not_empty, clk, rst, tok_count != 2'd0, !empty, "token lost")
  `STT_ASSERT_IMPLY(a_two_last, clk, rst, tok_count == 2'd2, !tok0.last && tok1.last, "bad last mark")
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import stt_pkg::*;

  typedef enum logic [5:0] {
    K_END, K_IDENT, K_INT, K_FLOAT, K_STR, K_CHR, K_LPAREN, K_RPAREN, K_LBRACK,
    K_RBRACK, K_LBRACE, K_RBRACE, K_SEMI, K_COMMA, K_COLON, K_DCOLON, K_DOT,
    K_ARROW, K_FATARROW, K_HASH, K_AT, K_DOLLAR, K_PLUS, K_MINUS, K_STAR,
    K_SLASH, K_PCT, K_EQEQ, K_NE, K_LT, K_GT, K_LE, K_GE, K_ANDAND, K_OROR,
    K_AMP, K_PIPE, K_CARET, K_TILDE, K_BANG, K_ASSIGN, K_PLUSEQ, K_MINUSEQ,
    K_STAREQ, K_SLASHEQ, K_INC, K_DEC
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_IDENT, S_NUM, S_STR, S_STR_ESC, S_CHR_OPEN, S_CHR_ESC,
    S_CHR_BODY, S_PUNCT, S_LINE, S_BLOCK, S_BLOCK_STAR
  } scan_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         typed;
    kind_t      kind;
  } dir_row_t;

  localparam logic [23:0] POS_TOP = 24'hFFFFFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES = 80;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full, empty;
  stt_in_t  in_item = '0;
  stt_out_t out_item;

  source_text_tokenizer uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always #10 clk = ~clk;

  // Scanner state mirrored by the predictor.
  scan_t       mode;
  logic [7:0]  held_byte;
  logic [23:0] tok_off, tok_line, tok_col, pos, cur_line, cur_col;
  logic        seen_dot;

  stt_out_t tokens_due[$];
  stt_in_t  text_feed[$];
  dir_row_t dir_rows[];

  int send_idle = 0, recv_idle = 0;
  int accepted = 0, tokens_seen = 0, texts_done = 0;
  int mismatches = 0, quiet_cycles = 0;
  int tokens_made = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  function automatic bit is_ws(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction
  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit needs_next(logic [7:0] b);
    return b == ":" || b == "+" || b == "-" || b == "*" || b == "/" || b == "=" ||
           b == "!" || b == "<" || b == ">" || b == "&" || b == "|";
  endfunction

  function automatic kind_t one_byte_kind(logic [7:0] b);
    case (b)
      "(": return K_LPAREN;  ")": return K_RPAREN;  "[": return K_LBRACK;
      "]": return K_RBRACK;  "{": return K_LBRACE;  "}": return K_RBRACE;
      ";": return K_SEMI;    ",": return K_COMMA;   ":": return K_COLON;
      ".": return K_DOT;     "#": return K_HASH;    "@": return K_AT;
      "$": return K_DOLLAR;  "+": return K_PLUS;    "-": return K_MINUS;
      "*": return K_STAR;    "/": return K_SLASH;   "%": return K_PCT;
      "<": return K_LT;      ">": return K_GT;      "&": return K_AMP;
      "|": return K_PIPE;    "^": return K_CARET;   "~": return K_TILDE;
      "!": return K_BANG;    "=": return K_ASSIGN;
      default: return K_END;
    endcase
  endfunction

  function automatic kind_t two_byte_kind(logic [7:0] a, logic [7:0] b);
    case ({a, b})
      {":", ":"}: return K_DCOLON;  {"+", "+"}: return K_INC;
      {"+", "="}: return K_PLUSEQ;  {"-", ">"}: return K_ARROW;
      {"-", "-"}: return K_DEC;     {"-", "="}: return K_MINUSEQ;
      {"*", "="}: return K_STAREQ;  {"/", "="}: return K_SLASHEQ;
      {"=", "="}: return K_EQEQ;    {"=", ">"}: return K_FATARROW;
      {"!", "="}: return K_NE;      {"<", "="}: return K_LE;
      {">", "="}: return K_GE;      {"&", "&"}: return K_ANDAND;
      {"|", "|"}: return K_OROR;
      default: return K_END;
    endcase
  endfunction

  task automatic clear_scanner();
    mode = S_IDLE; held_byte = '0; seen_dot = 1'b0;
    tok_off = '0; tok_line = 24'd1; tok_col = 24'd1;
    pos = '0; cur_line = 24'd1; cur_col = 24'd1;
  endtask

  task automatic step_pos(logic [7:0] b);
    if (pos < POS_TOP) pos++;
    if (b == CH_NL) begin
      if (cur_line < POS_TOP) cur_line++;
      cur_col = 24'd1;
    end else if (cur_col < POS_TOP) begin
      cur_col++;
    end
  endtask

  task automatic add_token(kind_t k, logic [23:0] off, logic [23:0] len,
                           logic [23:0] line, logic [23:0] col);
    stt_out_t t;
    t.token_kind = k; t.token_offset = off; t.token_length = len;
    t.token_line = line; t.token_column = col; t.last_of_run = 1'b0;
    tokens_due.push_back(t);
    tokens_made++;
  endtask

  task automatic add_started(kind_t k, logic [23:0] len);
    add_token(k, tok_off, len, tok_line, tok_col);
  endtask

  task automatic open_token(logic [7:0] b);
    mode = S_IDLE;
    if (is_ws(b)) begin
      step_pos(b);
      return;
    end
    tok_off = pos; tok_line = cur_line; tok_col = cur_col;
    if (is_letter(b) || b == CH_UNDER) mode = S_IDENT;
    else if (is_num(b)) begin
      seen_dot = 1'b0;
      mode = S_NUM;
    end else if (b == CH_DQ) mode = S_STR;
    else if (b == CH_SQ) mode = S_CHR_OPEN;
    else if (needs_next(b)) begin
      held_byte = b;
      mode = S_PUNCT;
    end else add_started(one_byte_kind(b), 24'd1);
    step_pos(b);
  endtask

  task automatic predict_tokens(stt_in_t it);
    int    n0;
    logic  [7:0] b;
    kind_t k;
    n0 = tokens_due.size();
    b = it.char_byte;
    if (it.end_of_input) begin
      // A token still open at the end is flushed with what it has; comments vanish.
      case (mode)
        S_IDENT: add_started(K_IDENT, pos - tok_off);
        S_NUM: add_started(seen_dot ? K_FLOAT : K_INT, pos - tok_off);
        S_STR, S_STR_ESC: add_started(K_STR, pos - tok_off);
        S_CHR_OPEN, S_CHR_ESC, S_CHR_BODY: add_started(K_CHR, pos - tok_off);
        S_PUNCT: add_started(one_byte_kind(held_byte), 24'd1);
        default: ;
      endcase
      add_token(K_END, pos, 24'd0, cur_line, cur_col);
      clear_scanner();
    end else begin
      case (mode)
        S_IDENT: begin
          if (is_letter(b) || is_num(b) || b == CH_UNDER) step_pos(b);
          else begin
            add_started(K_IDENT, pos - tok_off);
            open_token(b);
          end
        end
        S_NUM: begin
          if (is_num(b) || b == CH_DOT || b == CH_UNDER) begin
            if (b == CH_DOT) seen_dot = 1'b1;
            step_pos(b);
          end else begin
            add_started(seen_dot ? K_FLOAT : K_INT, pos - tok_off);
            open_token(b);
          end
        end
        S_STR: begin
          step_pos(b);
          if (b == CH_DQ) begin
            add_started(K_STR, pos - tok_off);
            mode = S_IDLE;
          end else if (b == CH_BSL) mode = S_STR_ESC;
        end
        S_STR_ESC: begin
          step_pos(b);
          mode = S_STR;
        end
        S_CHR_OPEN: begin
          step_pos(b);
          mode = (b == CH_BSL) ? S_CHR_ESC : S_CHR_BODY;
        end
        S_CHR_ESC: begin
          step_pos(b);
          mode = S_CHR_BODY;
        end
        S_CHR_BODY: begin
          // The closing byte is taken whatever it is.
          step_pos(b);
          add_started(K_CHR, pos - tok_off);
          mode = S_IDLE;
        end
        S_PUNCT: begin
          k = two_byte_kind(held_byte, b);
          if (held_byte == CH_SLASH && b == CH_SLASH) begin
            step_pos(b);
            mode = S_LINE;
          end else if (held_byte == CH_SLASH && b == CH_STAR) begin
            step_pos(b);
            mode = S_BLOCK;
          end else if (k != K_END) begin
            step_pos(b);
            add_started(k, 24'd2);
            mode = S_IDLE;
          end else begin
            add_started(one_byte_kind(held_byte), 24'd1);
            open_token(b);
          end
        end
        S_LINE: begin
          step_pos(b);
          if (b == CH_NL) mode = S_IDLE;
        end
        S_BLOCK: begin
          step_pos(b);
          if (b == CH_STAR) mode = S_BLOCK_STAR;
        end
        S_BLOCK_STAR: begin
          step_pos(b);
          if (b == CH_SLASH) mode = S_IDLE;
          else if (b != CH_STAR) mode = S_BLOCK;
        end
        default: open_token(b);
      endcase
    end
    if (tokens_due.size() > n0) tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic feed_byte(logic [7:0] b);
    stt_in_t it;
    it.char_byte = b;
    it.end_of_input = 1'b0;
    text_feed.push_back(it);
  endtask

  // Appends one lexical piece of random content, mostly well formed, or an end-of-input item.
  task automatic make_piece();
    int    sel, n;
    string punct;
    sel = $urandom_range(99);
    punct = "()[]{};,:.#@$+-*/%<>&|^~!=";
    if (sel < 24) begin
      feed_byte($urandom_range(1) ? 8'("a" + $urandom_range(25)) : CH_UNDER);
      n = $urandom_range(8);
      repeat (n) case ($urandom_range(3))
        0: feed_byte(8'("0" + $urandom_range(9)));
        1: feed_byte(CH_UNDER);
        2: feed_byte(8'("A" + $urandom_range(25)));
        default: feed_byte(8'("a" + $urandom_range(25)));
      endcase
    end else if (sel < 37) begin
      feed_byte(8'("0" + $urandom_range(9)));
      n = $urandom_range(6);
      repeat (n) case ($urandom_range(5))
        0: feed_byte(CH_DOT);
        1: feed_byte(CH_UNDER);
        default: feed_byte(8'("0" + $urandom_range(9)));
      endcase
    end else if (sel < 45) begin
      feed_byte(CH_DQ);
      n = $urandom_range(6);
      repeat (n) begin
        if ($urandom_range(4) == 0) begin
          feed_byte(CH_BSL);
          feed_byte($urandom_range(1) ? CH_DQ : 8'($urandom_range(32, 126)));
        end else feed_byte(8'($urandom_range(32, 126)));
      end
      if ($urandom_range(9) != 0) feed_byte(CH_DQ);
    end else if (sel < 51) begin
      feed_byte(CH_SQ);
      if ($urandom_range(2) == 0) feed_byte(CH_BSL);
      feed_byte(8'($urandom_range(32, 126)));
      feed_byte($urandom_range(5) != 0 ? CH_SQ : 8'($urandom_range(255)));
    end else if (sel < 71) begin
      feed_byte(8'(punct[$urandom_range(punct.len() - 1)]));
      if ($urandom_range(1)) feed_byte(8'(punct[$urandom_range(punct.len() - 1)]));
    end else if (sel < 81) begin
      feed_byte($urandom_range(2) == 0 ? 8'($urandom_range(9, 13)) : 8'd32);
    end else if (sel < 86) begin
      feed_byte(CH_SLASH);
      if ($urandom_range(1)) begin
        feed_byte(CH_SLASH);
        repeat ($urandom_range(5)) feed_byte(8'($urandom_range(255)));
        feed_byte(CH_NL);
      end else begin
        feed_byte(CH_STAR);
        repeat ($urandom_range(5)) feed_byte($urandom_range(2) == 0 ? CH_STAR
                                             : 8'($urandom_range(255)));
        feed_byte(CH_STAR);
        feed_byte(CH_SLASH);
      end
    end else if (sel < 96) begin
      feed_byte(8'($urandom_range(255)));
    end else begin
      text_feed.push_back('{char_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
    end
  endtask

  task automatic set_rates();
    if (accepted < 600) begin
      send_idle = 28; recv_idle = 45;
    end else if (accepted < 1150) begin
      send_idle = 45; recv_idle = 28;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  endtask

  // Offers one item and returns after the transfer, at the following falling edge.
  task automatic send_item(stt_in_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_tokens(it);
    accepted++;
    if (it.end_of_input) texts_done++;
    @(negedge clk);
  endtask

  // Receiver: random pops, with a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    stt_out_t exp_tok;
    if (!rst && pop && !empty) begin
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected token: kind %0d off %0d len %0d", out_item.token_kind,
                   out_item.token_offset, out_item.token_length);
      end else begin
        exp_tok = tokens_due.pop_front();
        if (out_item !== exp_tok) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"token mismatch: expected kind %0d off %0d len %0d line %0d col %0d ",
                      "last %0d, got kind %0d off %0d len %0d line %0d col %0d last %0d"},
                     exp_tok.token_kind, exp_tok.token_offset, exp_tok.token_length,
                     exp_tok.token_line, exp_tok.token_column, exp_tok.last_of_run,
                     out_item.token_kind, out_item.token_offset, out_item.token_length,
                     out_item.token_line, out_item.token_column, out_item.last_of_run);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d tokens outstanding", tokens_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stt_in_t it;
    int      n0;
    clear_scanner();
    dir_rows = '{
      '{8'd32, 1'b0, 1'b0, K_END}, '{"a", 1'b0, 1'b0, K_END},
      '{"_", 1'b0, 1'b0, K_END},   '{"9", 1'b0, 1'b0, K_END},
      '{"(", 1'b0, 1'b1, K_LPAREN}, '{"1", 1'b0, 1'b0, K_END},
      '{".", 1'b0, 1'b0, K_END},   '{"5", 1'b0, 1'b0, K_END},
      '{";", 1'b0, 1'b1, K_SEMI},  '{CH_DQ, 1'b0, 1'b0, K_END},
      '{CH_BSL, 1'b0, 1'b0, K_END}, '{CH_DQ, 1'b0, 1'b0, K_END},
      '{CH_DQ, 1'b0, 1'b1, K_STR}, '{CH_SQ, 1'b0, 1'b0, K_END},
      '{"q", 1'b0, 1'b0, K_END},   '{CH_SQ, 1'b0, 1'b1, K_CHR},
      '{"/", 1'b0, 1'b0, K_END},   '{"/", 1'b0, 1'b0, K_END},
      '{CH_NL, 1'b0, 1'b0, K_END}, '{"/", 1'b0, 1'b0, K_END},
      '{"*", 1'b0, 1'b0, K_END},   '{"*", 1'b0, 1'b0, K_END},
      '{"/", 1'b0, 1'b0, K_END},   '{"-", 1'b0, 1'b0, K_END},
      '{">", 1'b0, 1'b1, K_ARROW}, '{8'hFF, 1'b0, 1'b1, K_END},
      '{"=", 1'b0, 1'b0, K_END},   '{8'h00, 1'b1, 1'b1, K_END}
    };
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_rates();
    foreach (dir_rows[i]) begin
      it.char_byte = dir_rows[i].ch;
      it.end_of_input = dir_rows[i].eoi;
      n0 = tokens_made;
      send_item(it);
      // Rows with a kind typed in fix the kind of their last token.
      if (dir_rows[i].typed && tokens_made > n0)
        tokens_due[tokens_due.size() - 1].token_kind = dir_rows[i].kind;
    end
    while (accepted < RANDOM_ITEMS + dir_rows.size()) begin
      if (text_feed.size() == 0) make_piece();
      set_rates();
      if (accepted == 300) hold_req <= 1'b1;
      if (accepted == 700) begin
        push <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_item(text_feed.pop_front());
    end
    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d items in %0d complete texts; %0d tokens checked, %0d mismatches.",
             accepted, texts_done, tokens_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== source_text_tokenizer.f =====
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/stt_queue.sv
rtl/source_text_tokenizer.sv
verif/testbench.sv
